>>> rtl/set_membership_table_top_defines.svh
// Assertion macros used by the set membership table checker.
`ifndef SET_MEMBERSHIP_TABLE_TOP_DEFINES_SVH
`define SET_MEMBERSHIP_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/smt_pkg.sv
package smt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } t_dp_sts;

endpackage

>>> rtl/smt_ctrl.sv
module smt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  smt_pkg::t_dp_sts i_sts,
    output smt_pkg::t_dp_ctl o_ctl
);
    import smt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   commit;
    logic   load;

    // A new word may enter in the same cycle as the previous one is written back.
    assign commit     = (r_state == S_DONE) && !i_sts.out_stall;
    assign o_in_ready = (r_state == S_IDLE) || commit;
    assign load       = i_in_valid && o_in_ready;

    assign o_ctl.load    = load;
    assign o_ctl.compare = (r_state == S_CMP);
    assign o_ctl.commit  = commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (commit) begin
                    n_state = load ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/smt_datapath.sv
module smt_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smt_pkg::t_dp_ctl             i_ctl,
    output smt_pkg::t_dp_sts             o_sts,
    input  logic [smt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [smt_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_was_present,
    output logic [smt_pkg::POS_W-1:0]    o_position,
    output logic [smt_pkg::COUNT_W-1:0]  o_count,
    output logic                         o_status
);
    import smt_pkg::*;

    logic [VALUE_W-1:0] r_entry [CAPACITY];
    logic [OCC_W-1:0]   r_occ;
    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_value;
    logic [CAPACITY-1:0] r_hit;
    logic [VALUE_W-1:0] r_last;

    logic               r_out_valid;
    logic               r_was_present;
    logic [POS_W-1:0]   r_position;
    logic [COUNT_W-1:0] r_count;
    logic               r_status;

    logic [CAPACITY-1:0] hit;
    logic [IDX_W-1:0]    last_idx;
    logic                found;
    logic [IDX_W-1:0]    slot;
    logic [OCC_W-1:0]    n_occ;
    logic                n_status;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [VALUE_W-1:0]  wr_data;

    // Every occupied cell compares against the request value in parallel.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = (r_entry[i] == r_value) && (OCC_W'(i) < r_occ);
        end
    end

    assign last_idx = IDX_W'(r_occ - OCC_W'(1));

    // Entries are distinct, so at most one hit bit is set and an OR encodes it.
    always_comb begin
        slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_hit[i]) begin
                slot = slot | IDX_W'(i);
            end
        end
    end

    always_comb begin
        found    = (r_cmd != CMD_CLEAR) && (|r_hit);
        n_occ    = r_occ;
        n_status = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = slot;
        wr_data  = r_last;
        case (r_cmd)
            CMD_CLEAR: begin
                n_occ = '0;
            end
            CMD_INSERT: begin
                if (!found) begin
                    if (r_occ < OCC_W'(CAPACITY)) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_occ[IDX_W-1:0];
                        wr_data = r_value;
                        n_occ   = r_occ + OCC_W'(1);
                    end else begin
                        n_status = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (found) begin
                    wr_en = 1'b1;
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
        end
        if (i_ctl.compare) begin
            r_hit  <= hit;
            r_last <= r_entry[last_idx];
        end
        if (i_ctl.commit && wr_en) begin
            r_entry[wr_idx] <= wr_data;
        end
        if (i_ctl.commit) begin
            r_was_present <= found;
            r_position    <= found ? POS_W'(slot) : '0;
            r_count       <= COUNT_W'(n_occ);
            r_status      <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.commit) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_was_present   = r_was_present;
    assign o_position      = r_position;
    assign o_count         = r_count;
    assign o_status        = r_status;

endmodule

>>> rtl/set_membership_table_top.sv
// Each request word is registered, then compared in parallel across the register
// table, then written back, which updates the table and the output register. A new
// request is taken while idle or in the write-back cycle of the one before it.
// A full output register that is not taken holds the write-back until it drains.
// Reset (synchronous, active low) empties the set and the output register; the
// stored entries themselves are not cleared.
module set_membership_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [0] was_present, [4:1] position, [9:5] count
    output logic        m_axis_tuser   // [0] status
);
    import smt_pkg::*;

    t_dp_ctl            ctl;
    t_dp_sts            sts;
    logic               was_present;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;

    smt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    smt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (s_axis_tuser),
        .i_value       (s_axis_tdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_was_present (was_present),
        .o_position    (position),
        .o_count       (count),
        .o_status      (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, count, position, was_present};

endmodule

>>> rtl/smt_checker.sv
`include "set_membership_table_top_defines.svh"

module smt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import smt_pkg::*;

    logic        in_take;
    logic        out_wait;
    logic [16:0] out_word;
    logic        out_absent;
    logic        pos_zero;
    logic        out_reject;
    logic        reject_ok;

    assign in_take    = s_axis_tvalid && s_axis_tready;
    assign out_wait   = m_axis_tvalid && !m_axis_tready;
    assign out_word   = {m_axis_tuser, m_axis_tdata};
    assign out_absent = m_axis_tvalid && !m_axis_tdata[0];
    assign pos_zero   = (m_axis_tdata[4:1] == 4'd0);
    assign out_reject = m_axis_tvalid && m_axis_tuser;
    assign reject_ok  = !m_axis_tdata[0] && (m_axis_tdata[9:5] == COUNT_W'(CAPACITY));

    // A result word that is not taken must stay unchanged.
    `SMT_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(out_word), "result word not held")

    // An absent value always reports slot zero.
    `SMT_ASSERT_IMPL(a_absent_pos, out_absent, pos_zero, "absent value with a position")

    // A rejected insert only happens for an absent value with the table full.
    `SMT_ASSERT_IMPL(a_reject_full, out_reject, reject_ok, "insert rejected while not full")

    // The compare cycle always follows an accepted request word.
    `SMT_ASSERT_NEXT(a_in_gap, in_take, !s_axis_tready, "input ready straight after a word")

endmodule

bind set_membership_table_top smt_checker u_smt_checker (.*);

>>> tb/tb_set_membership_table_top.sv
`timescale 1ns / 1ps

module tb_set_membership_table_top;

    import smt_pkg::*;

    localparam int ITEMS       = 1750;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 24;

    typedef struct {
        logic               was_present;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic               status;
    } t_reply;

    // Shadow copy of the set and the queue of replies it predicts.
    class set_shadow;
        logic [VALUE_W-1:0] entries [CAPACITY];
        int                 held;
        t_reply             pending_replies [$];
        int                 errors;
        int                 replies_seen;
        int                 cmd_seen [4];
        int                 rejects;
        int                 hits;
        int                 max_held;

        function void note_request(t_cmd cmd, logic [VALUE_W-1:0] value);
            t_reply r;
            int     slot;
            logic   found;
            found  = 1'b0;
            slot   = 0;
            r.status = 1'b0;
            cmd_seen[cmd]++;
            if (cmd == CMD_CLEAR) begin
                held = 0;
            end else begin
                for (int i = 0; i < held; i++) begin
                    if (!found && entries[i] == value) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (cmd == CMD_INSERT && !found) begin
                    if (held < CAPACITY) begin
                        entries[held] = value;
                        held++;
                    end else begin
                        r.status = 1'b1;
                        rejects++;
                    end
                end else if (cmd == CMD_REMOVE && found) begin
                    // The last entry fills the freed slot.
                    entries[slot] = entries[held-1];
                    held--;
                end
            end
            if (found) hits++;
            if (held > max_held) max_held = held;
            r.was_present = found;
            r.position    = slot[POS_W-1:0];
            r.count       = held[COUNT_W-1:0];
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] word, logic flag);
            t_reply r;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
                return;
            end
            r = pending_replies.pop_front();
            if (word[0] !== r.was_present)
                report_mismatch("was_present", word[0], r.was_present);
            if (word[4:1] !== r.position)
                report_mismatch("position", word[4:1], r.position);
            if (word[9:5] !== r.count)
                report_mismatch("count", word[9:5], r.count);
            if (word[OUT_W-1:10] !== '0)
                report_mismatch("tdata padding", word[OUT_W-1:10], 0);
            if (flag !== r.status)
                report_mismatch("status", flag, r.status);
        endtask

        function int pending_count();
            return pending_replies.size();
        endfunction

        function logic [VALUE_W-1:0] held_value();
            if (held == 0) return $urandom;
            return entries[$urandom_range(0, held - 1)];
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;  // [31:0] value
    logic [1:0]         s_axis_tuser;  // [1:0] cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;  // [0] was_present, [4:1] position, [9:5] count
    logic               m_axis_tuser;  // [0] status

    set_shadow          sb = new;
    int                 tx_gap_max;
    int                 rx_stall_max;
    bit                 hold_request;
    int                 idle_cycles;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    set_membership_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Both handshakes are sampled at the edge, before any of this step's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(t_cmd'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: a random stall before each word, or one long hold-off on request.
    initial begin
        int stall;
        bit hold_done;
        m_axis_tready <= 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task send_request(t_cmd cmd, logic [VALUE_W-1:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 75) return sb.held_value();
        return $urandom;
    endfunction

    // Mode 0 fills the set, mode 1 drains it, mode 2 mixes everything.
    function t_cmd pick_cmd(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return CMD_CLEAR;
        case (mode)
            0: begin
                if (r < 72) return CMD_INSERT;
                if (r < 88) return CMD_LOOKUP;
                return CMD_REMOVE;
            end
            1: begin
                if (r < 65) return CMD_REMOVE;
                if (r < 85) return CMD_LOOKUP;
                return CMD_INSERT;
            end
            default: begin
                if (r < 35) return CMD_INSERT;
                if (r < 65) return CMD_REMOVE;
                return CMD_LOOKUP;
            end
        endcase
    endfunction

    task refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
        if ($urandom_range(0, 1)) begin
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7FFF_FFFF;
            value_pool[2] = 32'h0000_0000;
            value_pool[3] = 32'hFFFF_FFFF;
        end
    endtask

    initial begin
        int sent;
        int phase_len;
        int mode;
        int phase_no;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOOKUP;
        hold_request  = 1'b0;
        tx_gap_max    = 0;
        rx_stall_max  = 0;
        sent          = 0;
        phase_no      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty set, extremes, duplicates, swap on remove, clear.
        send_request(CMD_LOOKUP, 32'h0000_0005);
        send_request(CMD_REMOVE, 32'h0000_0005);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_request(CMD_LOOKUP, 32'h1234_5678);
        send_request(CMD_REMOVE, 32'h8000_0000);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_CLEAR,  32'hDEAD_BEEF);
        send_request(CMD_LOOKUP, 32'h7FFF_FFFF);
        send_request(CMD_REMOVE, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'hAAAA_AAAA);
        send_request(CMD_INSERT, 32'h5555_5555);
        send_request(CMD_CLEAR,  32'h0000_0000);
        send_request(CMD_CLEAR,  32'hFFFF_FFFF);
        sent = 20;

        while (sent < ITEMS) begin
            refresh_pool();
            phase_len    = $urandom_range(20, 80);
            mode         = (phase_no == 0) ? 0 : $urandom_range(0, 2);
            tx_gap_max   = $urandom_range(0, 2) == 0 ? 0 : 18;
            rx_stall_max = $urandom_range(0, 2) == 0 ? 0 : 18;
            if (phase_no == 3) begin
                // The receiver holds off while words keep coming, so the block backs up.
                tx_gap_max   = 0;
                hold_request = 1'b1;
            end
            for (int i = 0; i < phase_len && sent < ITEMS; i++) begin
                send_request(pick_cmd(mode), pick_value());
                sent++;
            end
            phase_no++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests: %0d lookups, %0d inserts, %0d removes, %0d clears.",
                 sent, sb.cmd_seen[CMD_LOOKUP], sb.cmd_seen[CMD_INSERT],
                 sb.cmd_seen[CMD_REMOVE], sb.cmd_seen[CMD_CLEAR]);
        $display("Checked %0d results: %0d hits, %0d full-set rejects, peak size %0d.",
                 sb.replies_seen, sb.hits, sb.rejects, sb.max_held);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/smt_pkg.sv
rtl/smt_ctrl.sv
rtl/smt_datapath.sv
rtl/set_membership_table_top.sv
rtl/smt_checker.sv
tb/tb_set_membership_table_top.sv
